FILE: sv/tfa_pkg.sv
// Shared types and constants of the temporal frame averager.
package tfa_pkg;

  // Port widths fixed by the stream and configuration formats
  localparam int DATA_W     = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;
  localparam int DEPTH_W    = 4;
  localparam int FPIX_W     = 17;

  // Register reset values
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 4'd5;
  localparam logic [FPIX_W-1:0]  FPIX_RST  = 17'd65536;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AVG_DEPTH    = 1'b0,
    CFG_FRAME_PIXELS = 1'b1
  } tfa_cfg_idx_t;

endpackage

FILE: sv/temporal_frame_average.sv
// Temporal moving average over a ring of stored frames, one memory row per pixel.
//
// Usage:
//   in_*  : raw pixels in raster order, one per request (in_tdata[15:0]).
//   out_* : one result per input pixel. out_tdata[15:0] is the mean of the
//           last avg_depth frames at that position (or the raw pixel during
//           warm-up), out_tuser flags a real mean, out_tlast marks the last
//           pixel of a frame.
//   cfg_* : write-only registers; index 0 = avg_depth, 1 = frame_pixels.
//           Writing avg_depth restarts warm-up. Write only while idle.
// Pipeline:
//   The single-port frame memory row for a pixel's position is read in the
//   accept cycle and written back when stage 1 advances, and the next
//   pixel's read must see that write, so in_tready stays low until the
//   previous pixel has written back its row. A result passes the row read,
//   sum + write-back and reciprocal multiply into the output reg, in order.
// Reset: control state clears (position, slot, stored-frame count, the
//   registers go to depth 5 and 65536 pixels); the memory is not cleared,
//   warm-up fills every slot that averaging later reads, unless the frame grows.
// Backpressure: a stalled output holds, the pipe fills behind it and
//   in_tready drops; nothing is lost or repeated.
module temporal_frame_average #(
  parameter int MAX_FRAMES = 8,
  parameter int MAX_PIXELS = 65536,
  parameter int PIXEL_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request in
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tfa_pkg::DATA_W-1:0]     in_tdata,   // [15:0] pixel_value
  // result out
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tfa_pkg::DATA_W-1:0]     out_tdata,  // [15:0] out_value
  output logic                           out_tuser,  // [0] averaged
  output logic                           out_tlast,  // frame_end
  // configuration
  input  logic                           cfg_we,
  input  logic [tfa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tfa_pkg::*;

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DEP_W  = $clog2(MAX_FRAMES + 1);
  localparam int POS_W  = $clog2(MAX_PIXELS);
  localparam int NPX_W  = $clog2(MAX_PIXELS + 1);
  localparam int LG_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SUM_W  = PIXEL_BITS + LG_W;
  // floor(n/d) == (n * ceil(2^K/d)) >> K for n < 2^SUM_W, d <= 2^LG_W
  localparam int K      = SUM_W + LG_W;
  localparam int M_W    = K + 1;
  localparam int PROD_W = SUM_W + M_W;

  typedef logic [MAX_FRAMES-1:0][PIXEL_BITS-1:0] row_t;

  // ---------------------------------------------------------------- config
  logic [DEPTH_W-1:0] depth_cfg_r;
  logic [FPIX_W-1:0]  fpix_cfg_r;
  logic [DEP_W-1:0]   depth_eff;
  logic [NPX_W-1:0]   npix_eff;

  always_comb begin
    if (depth_cfg_r == '0) begin
      depth_eff = DEP_W'(1);
    end else if (32'(depth_cfg_r) > 32'(MAX_FRAMES)) begin
      depth_eff = DEP_W'(MAX_FRAMES);
    end else begin
      depth_eff = DEP_W'(depth_cfg_r);
    end
    if (fpix_cfg_r == '0) begin
      npix_eff = NPX_W'(1);
    end else if (32'(fpix_cfg_r) > 32'(MAX_PIXELS)) begin
      npix_eff = NPX_W'(MAX_PIXELS);
    end else begin
      npix_eff = NPX_W'(fpix_cfg_r);
    end
  end

  // reciprocal table, entry 0 unused
  logic [M_W-1:0] recip_tbl [MAX_FRAMES+1];
  assign recip_tbl[0] = '0;
  for (genvar g = 1; g <= MAX_FRAMES; g++) begin : g_recip
    localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << K) + 64'(g) - 64'd1) / 64'(g));
    assign recip_tbl[g] = RECIP;
  end

  // ---------------------------------------------------------------- sequencing state
  logic [POS_W-1:0]  pos_r;
  logic [SLOT_W-1:0] cur_slot_r;
  logic [DEP_W-1:0]  stored_r;

  logic [POS_W-1:0]  pos_eff;
  logic              last_now;
  logic              warm_now;
  logic [SLOT_W-1:0] slot_now;
  logic [SLOT_W-1:0] slot_inc;
  logic              in_acc;

  always_comb begin
    if (NPX_W'(pos_r) >= npix_eff) begin
      pos_eff = POS_W'(npix_eff - NPX_W'(1));
    end else begin
      pos_eff = pos_r;
    end
    last_now = (NPX_W'(pos_eff) == npix_eff - NPX_W'(1));
    warm_now = (stored_r < depth_eff);
    if (warm_now) begin
      slot_now = SLOT_W'(stored_r);
    end else if (DEP_W'(cur_slot_r) >= depth_eff) begin
      slot_now = '0;
    end else begin
      slot_now = cur_slot_r;
    end
    // wrap the averaging slot at the depth
    if (DEP_W'(slot_now) + DEP_W'(1) == depth_eff) begin
      slot_inc = '0;
    end else begin
      slot_inc = slot_now + SLOT_W'(1);
    end
  end

  // ---------------------------------------------------------------- pipe control
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_load, s2_hold, s1_adv;

  assign out_load  = s2_v_r && (!out_v_r || out_tready);
  assign s2_hold   = s2_v_r && !out_load;
  assign s1_adv    = s1_v_r && !s2_hold;
  assign in_tready = !s1_v_r;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_cfg_r <= DEPTH_RST;
      fpix_cfg_r  <= FPIX_RST;
      pos_r       <= '0;
      cur_slot_r  <= '0;
      stored_r    <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (tfa_cfg_idx_t'(cfg_addr))
          CFG_AVG_DEPTH: begin
            depth_cfg_r <= cfg_wdata[DEPTH_W-1:0];
            pos_r       <= '0;
            cur_slot_r  <= '0;
            stored_r    <= '0;
          end
          CFG_FRAME_PIXELS: fpix_cfg_r <= cfg_wdata[FPIX_W-1:0];
          default: ;
        endcase
      end else if (in_acc) begin
        pos_r <= last_now ? '0 : pos_eff + POS_W'(1);
        if (last_now) begin
          if (warm_now) begin
            stored_r <= stored_r + DEP_W'(1);
          end else begin
            cur_slot_r <= slot_inc;
          end
        end
      end

      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (out_load) begin
        s2_v_r <= 1'b0;
      end

      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- frame memory
  // One row per pixel position, one lane per frame slot.
  row_t              frame_mem [MAX_PIXELS];
  row_t              rd_row_r;
  row_t              new_row;

  // stage 1 payload
  logic [POS_W-1:0]      s1_pos_r;
  logic [SLOT_W-1:0]     s1_slot_r;
  logic [PIXEL_BITS-1:0] s1_pix_r;
  logic                  s1_avg_r;
  logic                  s1_last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_row_r <= frame_mem[pos_eff];
    end
    if (s1_adv) begin
      frame_mem[s1_pos_r] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r  <= pos_eff;
      s1_slot_r <= slot_now;
      s1_pix_r  <= in_tdata[PIXEL_BITS-1:0];
      s1_avg_r  <= !warm_now;
      s1_last_r <= last_now;
    end
  end

  // merge the new sample, sum the live slots
  logic [SUM_W-1:0] sum_now;

  always_comb begin
    new_row            = rd_row_r;
    new_row[s1_slot_r] = s1_pix_r;
    sum_now            = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (i < 32'(depth_eff)) begin
        sum_now = sum_now + SUM_W'(new_row[i]);
      end
    end
  end

  // stage 2 payload
  logic [SUM_W-1:0]      s2_sum_r;
  logic [M_W-1:0]        s2_recip_r;
  logic [PIXEL_BITS-1:0] s2_pix_r;
  logic                  s2_avg_r;
  logic                  s2_last_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_sum_r   <= sum_now;
      s2_recip_r <= recip_tbl[depth_eff];
      s2_pix_r   <= s1_pix_r;
      s2_avg_r   <= s1_avg_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // divide by depth: reciprocal multiply, quotient is the upper bits
  logic [PROD_W-1:0]     prod;
  logic [PIXEL_BITS-1:0] quot;

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(s2_recip_r);
  assign quot = prod[K +: PIXEL_BITS];

  // ---------------------------------------------------------------- output register
  logic [DATA_W-1:0] out_data_r;
  logic              out_avg_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= DATA_W'(s2_avg_r ? quot : s2_pix_r);
      out_avg_r  <= s2_avg_r;
      out_last_r <= s2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_avg_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- assertions
  // write-back stage never overlaps the next row read
  a_s1_single: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> !s1_v_r)
    else $error("stage 1 held a second pixel after write-back");

  // warm-up count never runs past the depth
  a_stored_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= depth_eff)
    else $error("stored frame count exceeds depth");

  // averaging slot only moves once warm-up is over
  a_slot_warmup: assert property (@(posedge clk) disable iff (!rst_n)
    warm_now |-> cur_slot_r == '0)
    else $error("slot advanced during warm-up");

  // a stalled result keeps the pixel behind it in stage 2
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_v_r && !out_tready) |=> s2_v_r)
    else $error("stage 2 pixel dropped under backpressure");

endmodule

FILE: test/tb_temporal_frame_average.sv
// Self-checking testbench for temporal_frame_average: directed table, then random frame phases.
`timescale 1ns / 100ps
module tb_temporal_frame_average;
  import tfa_pkg::*;

  localparam int NFRAMES   = 8;      // slots in the frame ring
  localparam int NPIX      = 65536;  // largest frame
  localparam int RAND_REQS = 1850;   // random pixel requests

  // One result as it leaves the block
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              averaged;
    logic              frame_end;
  } pix_result_t;

  typedef enum logic { ROW_PIXEL, ROW_WRITE } row_kind_t;

  // Directed stimulus row: a pixel request or a register write
  typedef struct {
    row_kind_t             kind;
    tfa_cfg_idx_t          reg_idx;
    logic [CFG_DATA_W-1:0] data;     // pixel value or register value
    bit                    typed;    // expected result written in the row
    pix_result_t           want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata;    // [15:0] pixel_value
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;   // [15:0] out_value
  logic                  out_tuser;   // [0] averaged
  logic                  out_tlast;   // frame_end
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow of the block: frame ring, registers and frame counters
  bit   [DATA_W-1:0]  ring_mem [0:NFRAMES*NPIX-1];
  logic [DEPTH_W-1:0] depth_q;
  logic [FPIX_W-1:0]  fpix_q;
  int unsigned        pos_q;
  int unsigned        slot_q;
  int unsigned        filled_q;   // frames stored during warm-up

  pix_result_t pending_q[$];     // expected results, oldest first
  pix_result_t head_r;
  int          errors;
  int          burst_left;

  temporal_frame_average DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far past the slowest correct run
  initial begin
    #2000000;
    $display("tb_temporal_frame_average NOT OK");
    $finish;
  end

  // Depth 0 acts as 1, anything past the ring size as the ring size
  function automatic int unsigned depth_eff();
    if (depth_q == 0) return 1;
    if (depth_q > NFRAMES) return NFRAMES;
    return 32'(depth_q);
  endfunction

  // Frame size 0 acts as 1, oversize as the largest frame
  function automatic int unsigned frame_len();
    if (fpix_q == 0) return 1;
    if (fpix_q > NPIX) return NPIX;
    return 32'(fpix_q);
  endfunction

  // Store one pixel in the ring and work out what the block returns for it
  function automatic pix_result_t average_pixel(input logic [DATA_W-1:0] pix);
    int unsigned depth;
    int unsigned npix;
    int unsigned pos;
    int unsigned slot;
    int unsigned sum;
    int unsigned s;
    pix_result_t r;
    depth = depth_eff();
    npix  = frame_len();
    // a position left past a shrunken frame ends the frame right here
    pos = (pos_q >= npix) ? npix - 1 : pos_q;
    r.frame_end = (pos == npix - 1);
    if (filled_q < depth) begin
      // warm-up: fill slot k with frame k, pass the pixel through
      ring_mem[filled_q*NPIX + pos] = pix;
      r.value    = pix;
      r.averaged = 1'b0;
      if (r.frame_end) filled_q++;
    end else begin
      slot = (slot_q >= depth) ? 0 : slot_q;
      ring_mem[slot*NPIX + pos] = pix;
      sum = 0;
      for (s = 0; s < depth; s++) sum += 32'(ring_mem[s*NPIX + pos]);
      r.value    = DATA_W'(sum / depth);   // sum is wide, no wrap
      r.averaged = 1'b1;
      if (r.frame_end) slot_q = (slot + 1) % depth;
    end
    pos_q = r.frame_end ? 0 : pos + 1;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Stop requesting and wait until every expected result is out
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(input tfa_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_AVG_DEPTH) begin
      // depth write restarts warm-up from the first pixel
      depth_q  = val[DEPTH_W-1:0];
      filled_q = 0;
      slot_q   = 0;
      pos_q    = 0;
    end else begin
      fpix_q = val[FPIX_W-1:0];
    end
  endtask

  // One pixel request; the sender runs in bursts, mostly with idle gaps between
  task automatic send_pixel(input logic [DATA_W-1:0] pix, input bit typed,
                            input pix_result_t want);
    pix_result_t got;
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = average_pixel(pix);
    pending_q.push_back(typed ? want : got);
    burst_left--;
  endtask

  function automatic stim_row_t pix_row(input logic [DATA_W-1:0] v);
    stim_row_t r;
    r.kind    = ROW_PIXEL;
    r.reg_idx = CFG_AVG_DEPTH;
    r.data    = CFG_DATA_W'(v);
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input logic [DATA_W-1:0] v,
                                        input logic [DATA_W-1:0] ev,
                                        input bit ea, input bit el);
    stim_row_t r;
    r       = pix_row(v);
    r.typed = 1'b1;
    r.want  = '{value: ev, averaged: ea, frame_end: el};
    return r;
  endfunction

  function automatic stim_row_t reg_row(input tfa_cfg_idx_t idx,
                                        input logic [CFG_DATA_W-1:0] v);
    stim_row_t r;
    r         = pix_row('0);
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.data    = v;
    return r;
  endfunction

  // Receiver: out_tready follows a stall pattern that changes every so often
  initial begin
    int cyc;
    int stall_mode;
    int stall_hold;
    out_tready = 1'b0;
    cyc        = 0;
    stall_mode = 0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 150 == 0) stall_mode = $urandom_range(0, 3);
      if (stall_hold > 0) begin
        out_tready = 1'b0;
        stall_hold--;
      end else begin
        case (stall_mode)
          0: out_tready = 1'b1;                             // no stalls
          1: out_tready = 1'($urandom_range(0, 1));         // coin toss
          2: out_tready = (cyc % 3 != 0);                   // regular beat
          default: begin                                    // rare long stalls
            out_tready = 1'b1;
            if ($urandom_range(0, 19) == 0) begin
              out_tready = 1'b0;
              stall_hold = $urandom_range(5, 25);
            end
          end
        endcase
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", out_tdata));
      end else begin
        head_r = pending_q.pop_front();
        if (out_tdata !== head_r.value)
          report_mismatch($sformatf("out_value %h, expected %h", out_tdata, head_r.value));
        if (out_tuser !== head_r.averaged)
          report_mismatch($sformatf("averaged %b, expected %b", out_tuser, head_r.averaged));
        if (out_tlast !== head_r.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b", out_tlast, head_r.frame_end));
      end
    end
  end

  initial begin
    stim_row_t             plan[$];
    int                    rand_cnt;
    int                    len;
    int                    mode;
    int                    k;
    int unsigned           npix_new;
    logic [CFG_DATA_W-1:0] dval;
    logic [DATA_W-1:0]     px;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = CFG_AVG_DEPTH;
    cfg_wdata  = '0;
    errors     = 0;
    burst_left = 0;
    depth_q    = DEPTH_RST;
    fpix_q     = FPIX_RST;
    pos_q      = 0;
    slot_q     = 0;
    filled_q   = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Right after reset: depth 5, huge frame, so pixels pass through
    plan.push_back(chk_row(16'h0000, 16'h0000, 1'b0, 1'b0));
    plan.push_back(chk_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    plan.push_back(chk_row(16'hA5A5, 16'hA5A5, 1'b0, 1'b0));
    // shrink the frame under the current position: this pixel ends the frame
    plan.push_back(reg_row(CFG_FRAME_PIXELS, 17'd2));
    plan.push_back(chk_row(16'h1234, 16'h1234, 1'b0, 1'b1));
    // depth 0 acts as 1: one warm-up frame, then each pixel is its own mean
    plan.push_back(reg_row(CFG_AVG_DEPTH, 17'd0));
    plan.push_back(chk_row(16'd100, 16'd100, 1'b0, 1'b0));
    plan.push_back(chk_row(16'd200, 16'd200, 1'b0, 1'b1));
    plan.push_back(chk_row(16'd300, 16'd300, 1'b1, 1'b0));
    plan.push_back(chk_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    // frame size 0 acts as 1, depth 15 acts as 8: every pixel ends a frame
    plan.push_back(reg_row(CFG_FRAME_PIXELS, 17'd0));
    plan.push_back(reg_row(CFG_AVG_DEPTH, 17'd15));
    repeat (8) plan.push_back(chk_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    // eight full-scale values: the sum must not wrap
    plan.push_back(chk_row(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    plan.push_back(pix_row(16'h0000));
    plan.push_back(pix_row(16'h8001));
    plan.push_back(pix_row(16'h7FFE));
    // oversize frame acts as the largest frame; depth 8 exactly
    plan.push_back(reg_row(CFG_FRAME_PIXELS, 17'h1FFFF));
    plan.push_back(reg_row(CFG_AVG_DEPTH, 17'd8));
    plan.push_back(chk_row(16'h5A5A, 16'h5A5A, 1'b0, 1'b0));
    plan.push_back(chk_row(16'h0001, 16'h0001, 1'b0, 1'b0));
    plan.push_back(reg_row(CFG_FRAME_PIXELS, 17'd3));
    plan.push_back(reg_row(CFG_AVG_DEPTH, 17'd3));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        write_reg(plan[i].reg_idx, plan[i].data);
      else
        send_pixel(plan[i].data[DATA_W-1:0], plan[i].typed, plan[i].want);
    end

    // Random phases: new settings, then frames past warm-up, capped at 300 pixels.
    // A larger frame always comes with a depth write, so warm-up refills every
    // position before any mean reads it.
    rand_cnt = 0;
    while (rand_cnt < RAND_REQS) begin
      mode = $urandom_range(0, 9);
      if (mode == 0 && frame_len() > 1) begin
        // shrink only, mid-stream
        npix_new = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, frame_len() - 1);
        write_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(npix_new));
      end else begin
        if (mode != 1) begin
          if ($urandom_range(0, 15) == 0)
            npix_new = 0;
          else if ($urandom_range(0, 7) == 0)
            npix_new = $urandom_range(17, 48);
          else
            npix_new = $urandom_range(1, 16);
          write_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(npix_new));
        end
        k = $urandom_range(0, 11);
        if (k <= 7)
          dval = CFG_DATA_W'(k + 1);
        else if (k == 8)
          dval = '0;
        else
          dval = CFG_DATA_W'($urandom_range(9, 15));
        // junk above the depth field is ignored
        if ($urandom_range(0, 3) == 0)
          dval = dval | (CFG_DATA_W'($urandom) & ~CFG_DATA_W'(17'hF));
        write_reg(CFG_AVG_DEPTH, dval);
      end

      len = (depth_eff() + $urandom_range(1, 3)) * frame_len()
            + $urandom_range(0, frame_len() - 1);
      if (len > 300) len = 300;
      repeat (len) begin
        k = $urandom_range(0, 9);
        if (k == 0)
          px = '0;
        else if (k == 1)
          px = '1;
        else if (k == 2)
          px = DATA_W'($urandom_range(65000, 65535));
        else
          px = DATA_W'($urandom_range(0, 65535));
        send_pixel(px, 1'b0, '0);
        rand_cnt++;
      end
    end

    wait_idle();
    // anything arriving after the expected results have drained is a stray result
    repeat (12) @(negedge clk);
    if (errors == 0)
      $display("tb_temporal_frame_average OK");
    else
      $display("tb_temporal_frame_average NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
sv/tfa_pkg.sv
sv/temporal_frame_average.sv
test/tb_temporal_frame_average.sv
